// ----- sv/qva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion / vector ALU package
// Operation codes and the shared data width for the quaternion and vector ALU.
// ----------------------------------------------------------------------------
package qva_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        FN_CONJ   = 3'd0,
        FN_QMUL   = 3'd1,
        FN_ROTATE = 3'd2,
        FN_DOT    = 3'd3,
        FN_CROSS  = 3'd4,
        FN_SCALE  = 3'd5
    } func_t;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] a_w;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_w;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] r_w;
        logic signed [DATA_W-1:0] r_x;
        logic signed [DATA_W-1:0] r_y;
        logic signed [DATA_W-1:0] r_z;
        logic                     saturated;
    } rsp_t;

endpackage

// ----- sv/qva_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion / vector ALU channels
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
interface qva_req_if;
    logic          valid;
    logic          ready;
    qva_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qva_rsp_if;
    logic          valid;
    logic          ready;
    qva_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/quaternion_vector_alu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion / vector ALU core
// Conjugate, Hamilton product, rotation, dot, cross and scale in fixed point.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// req      in         func, a_w..a_z, b_w..b_z
// rsp      out        r_w, r_x, r_y, r_z, saturated
//
// Six register stages: first products, first sums, saturate, second products,
// second sums, output. One word enters per cycle while the pipe is not stalled.
// A stall freezes the whole pipe (ready is high while the output stage is
// empty or being taken). Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module quaternion_vector_alu_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    qva_req_if.sink      req,
    qva_rsp_if.source    rsp
);

    localparam int W  = qva_pkg::DATA_W;
    localparam int PW = 2 * W;
    localparam int SW = PW + 3;
    localparam int NS = 6;

    localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SMIN = -SW'(64'sd2147483648);

    logic              adv;
    logic [NS-1:0]     vld_reg;

    assign adv       = !vld_reg[NS-1] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], req.valid};
        end
    end

    function automatic logic signed [SW-1:0] fmul(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
        logic signed [PW-1:0] p;
        begin
            p = PW'(x) * PW'(y);
            fmul = SW'(p >>> FRAC_BITS);
        end
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        begin
            if (v > SMAX)      sat = SMAX[W-1:0];
            else if (v < SMIN) sat = SMIN[W-1:0];
            else               sat = v[W-1:0];
        end
    endfunction

    function automatic logic ovf(input logic signed [SW-1:0] v);
        begin
            ovf = (v > SMAX) || (v < SMIN);
        end
    endfunction

    // ---- stage 1: first-level products (16 lanes) ----
    // Lane meaning depends on func; each sum below picks its lanes.
    logic [2:0]              f1_reg;
    logic signed [W-1:0]     a1_reg [4];
    logic signed [SW-1:0]    p1_reg [16];
    logic signed [SW-1:0]    p1_next [16];
    qva_pkg::req_t           d;

    assign d = req.data;

    always_comb
    begin
        // Products a_i*b_j indexed 4*i+j with w,x,y,z = 0..3.
        p1_next[0]  = fmul(d.a_w, d.b_w);
        p1_next[1]  = fmul(d.a_w, d.b_x);
        p1_next[2]  = fmul(d.a_w, d.b_y);
        p1_next[3]  = fmul(d.a_w, d.b_z);
        p1_next[4]  = fmul(d.a_x, d.b_w);
        p1_next[5]  = fmul(d.a_x, d.b_x);
        p1_next[6]  = fmul(d.a_x, d.b_y);
        p1_next[7]  = fmul(d.a_x, d.b_z);
        p1_next[8]  = fmul(d.a_y, d.b_w);
        p1_next[9]  = fmul(d.a_y, d.b_x);
        p1_next[10] = fmul(d.a_y, d.b_y);
        p1_next[11] = fmul(d.a_y, d.b_z);
        p1_next[12] = fmul(d.a_z, d.b_w);
        p1_next[13] = fmul(d.a_z, d.b_x);
        p1_next[14] = fmul(d.a_z, d.b_y);
        p1_next[15] = fmul(d.a_z, d.b_z);
        // Conjugate reuses lanes 0..3 for a_w and the negated a_x..a_z.
        if (d.func == qva_pkg::FN_CONJ)
        begin
            p1_next[0] = SW'(d.a_w);
            p1_next[1] = -SW'(d.a_x);
            p1_next[2] = -SW'(d.a_y);
            p1_next[3] = -SW'(d.a_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg    <= d.func;
            a1_reg[0] <= d.a_w;
            a1_reg[1] <= d.a_x;
            a1_reg[2] <= d.a_y;
            a1_reg[3] <= d.a_z;
            for (int i = 0; i < 16; i++) p1_reg[i] <= p1_next[i];
        end
    end

    // ---- stage 2: first sums ----
    logic [2:0]           f2_reg;
    logic signed [W-1:0]  a2_reg [4];
    logic signed [SW-1:0] s2_reg [4];
    logic signed [SW-1:0] s2_next [4];

    always_comb
    begin
        s2_next[0] = '0;
        s2_next[1] = '0;
        s2_next[2] = '0;
        s2_next[3] = '0;
        case (f1_reg)
            qva_pkg::FN_CONJ:
            begin
                for (int i = 0; i < 4; i++) s2_next[i] = p1_reg[i];
            end
            qva_pkg::FN_QMUL:
            begin
                s2_next[0] = p1_reg[0] - p1_reg[5] - p1_reg[10] - p1_reg[15];
                s2_next[1] = p1_reg[1] + p1_reg[4] + p1_reg[11] - p1_reg[14];
                s2_next[2] = p1_reg[2] - p1_reg[7] + p1_reg[8] + p1_reg[13];
                s2_next[3] = p1_reg[3] + p1_reg[6] - p1_reg[9] + p1_reg[12];
            end
            qva_pkg::FN_ROTATE:
            begin
                s2_next[0] = p1_reg[5] + p1_reg[10] + p1_reg[15];
                s2_next[1] = p1_reg[1] - p1_reg[11] + p1_reg[14];
                s2_next[2] = p1_reg[2] + p1_reg[7] - p1_reg[13];
                s2_next[3] = p1_reg[3] - p1_reg[6] + p1_reg[9];
            end
            qva_pkg::FN_DOT:
            begin
                s2_next[0] = p1_reg[5] + p1_reg[10] + p1_reg[15];
            end
            qva_pkg::FN_CROSS:
            begin
                s2_next[1] = p1_reg[11] - p1_reg[14];
                s2_next[2] = p1_reg[13] - p1_reg[7];
                s2_next[3] = p1_reg[6] - p1_reg[9];
            end
            qva_pkg::FN_SCALE:
            begin
                s2_next[1] = p1_reg[4];
                s2_next[2] = p1_reg[8];
                s2_next[3] = p1_reg[12];
            end
            default:
            begin
                s2_next[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg <= f1_reg;
            for (int i = 0; i < 4; i++)
            begin
                a2_reg[i] <= a1_reg[i];
                s2_reg[i] <= s2_next[i];
            end
        end
    end

    // ---- stage 3: saturate first result ----
    logic [2:0]          f3_reg;
    logic signed [W-1:0] a3_reg [4];
    logic signed [W-1:0] t3_reg [4];
    logic                sat3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_reg   <= f2_reg;
            sat3_reg <= ovf(s2_reg[0]) || ovf(s2_reg[1]) || ovf(s2_reg[2])
                        || ovf(s2_reg[3]);
            for (int i = 0; i < 4; i++)
            begin
                a3_reg[i] <= a2_reg[i];
                t3_reg[i] <= sat(s2_reg[i]);
            end
        end
    end

    // ---- stage 4: second products (t_i * a_j) ----
    logic [2:0]           f4_reg;
    logic                 sat4_reg;
    logic signed [W-1:0]  t4_reg [4];
    logic signed [SW-1:0] p4_reg [16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f4_reg   <= f3_reg;
            sat4_reg <= sat3_reg;
            for (int i = 0; i < 4; i++)
            begin
                t4_reg[i] <= t3_reg[i];
                for (int j = 0; j < 4; j++)
                    p4_reg[4*i+j] <= fmul(t3_reg[i], a3_reg[j]);
            end
        end
    end

    // ---- stage 5: second sums ----
    logic [2:0]           f5_reg;
    logic                 sat5_reg;
    logic signed [W-1:0]  t5_reg [4];
    logic signed [SW-1:0] s5_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f5_reg   <= f4_reg;
            sat5_reg <= sat4_reg;
            for (int i = 0; i < 4; i++) t5_reg[i] <= t4_reg[i];
            s5_reg[0] <= '0;
            s5_reg[1] <= p4_reg[1] + p4_reg[4] + p4_reg[11] - p4_reg[14];
            s5_reg[2] <= p4_reg[2] - p4_reg[7] + p4_reg[8] + p4_reg[13];
            s5_reg[3] <= p4_reg[3] + p4_reg[6] - p4_reg[9] + p4_reg[12];
        end
    end

    // ---- stage 6: output ----
    qva_pkg::rsp_t out_reg;
    qva_pkg::rsp_t out_next;

    always_comb
    begin
        out_next = '0;
        if (f5_reg == qva_pkg::FN_ROTATE)
        begin
            out_next.r_x       = sat(s5_reg[1]);
            out_next.r_y       = sat(s5_reg[2]);
            out_next.r_z       = sat(s5_reg[3]);
            out_next.saturated = sat5_reg || ovf(s5_reg[1]) || ovf(s5_reg[2])
                                 || ovf(s5_reg[3]);
        end
        else if (f5_reg <= qva_pkg::FN_SCALE)
        begin
            out_next.r_w       = t5_reg[0];
            out_next.r_x       = t5_reg[1];
            out_next.r_y       = t5_reg[2];
            out_next.r_z       = t5_reg[3];
            out_next.saturated = sat5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.data = out_reg;

endmodule

// ----- dv/qva_tb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion / vector ALU test package
// Constants and helpers used by the testbench; tb_top holds the channels.
// ----------------------------------------------------------------------------
// The design package and channel interfaces are compiled from the RTL tree;
// this file only collects the latency constant and fixed-point helper that the test top relies on.
package qva_tb_pkg;

    localparam int LATENCY = 6;

    // Floored fixed-point product of two 32-bit values.
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        begin
            p = a * b;
            return p >>> 16;
        end
    endfunction

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion / vector ALU testbench
// Drives operand words through the ALU with random gaps on both channels and
// checks every result word against a directed table or a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int RAND_WORDS = 850;

    typedef struct {
        qva_pkg::req_t word;
        bit            known;
        qva_pkg::rsp_t result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    qva_req_if req ();
    qva_rsp_if rsp ();

    quaternion_vector_alu_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    qva_pkg::rsp_t result_queue[$];
    stim_row_t     dir_rows[$];
    int            error_count;
    int            words_sent;
    int            results_seen;
    int            sat_seen;

    qva_pkg::func_t func_list[6] = '{qva_pkg::FN_CONJ, qva_pkg::FN_QMUL, qva_pkg::FN_ROTATE,
                                     qva_pkg::FN_DOT, qva_pkg::FN_CROSS, qva_pkg::FN_SCALE};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint clip32(input longint v, inout bit flag);
        begin
            if (v > S32_MAX)
            begin
                flag = 1'b1;
                return S32_MAX;
            end
            if (v < S32_MIN)
            begin
                flag = 1'b1;
                return S32_MIN;
            end
            return v;
        end
    endfunction

    // Computes the result word that the ALU should give for one operand word.
    function automatic qva_pkg::rsp_t alu_result(input qva_pkg::req_t w);
        longint        aw, ax, ay, az, bw, bx, by, bz;
        longint        tw, tx, ty, tz;
        longint        rw, rx, ry, rz;
        bit            flag;
        qva_pkg::rsp_t r;
        begin
            aw = w.a_w; ax = w.a_x; ay = w.a_y; az = w.a_z;
            bw = w.b_w; bx = w.b_x; by = w.b_y; bz = w.b_z;
            rw = 0; rx = 0; ry = 0; rz = 0;
            flag = 1'b0;
            case (w.func)
                qva_pkg::FN_CONJ:
                begin
                    rw = aw;
                    rx = clip32(-ax, flag);
                    ry = clip32(-ay, flag);
                    rz = clip32(-az, flag);
                end
                qva_pkg::FN_QMUL:
                begin
                    rw = clip32(qva_tb_pkg::fx_mul(aw, bw) - qva_tb_pkg::fx_mul(ax, bx)
                                - qva_tb_pkg::fx_mul(ay, by) - qva_tb_pkg::fx_mul(az, bz),
                                flag);
                    rx = clip32(qva_tb_pkg::fx_mul(aw, bx) + qva_tb_pkg::fx_mul(ax, bw)
                                + qva_tb_pkg::fx_mul(ay, bz) - qva_tb_pkg::fx_mul(az, by),
                                flag);
                    ry = clip32(qva_tb_pkg::fx_mul(aw, by) - qva_tb_pkg::fx_mul(ax, bz)
                                + qva_tb_pkg::fx_mul(ay, bw) + qva_tb_pkg::fx_mul(az, bx),
                                flag);
                    rz = clip32(qva_tb_pkg::fx_mul(aw, bz) + qva_tb_pkg::fx_mul(ax, by)
                                - qva_tb_pkg::fx_mul(ay, bx) + qva_tb_pkg::fx_mul(az, bw),
                                flag);
                end
                qva_pkg::FN_ROTATE:
                begin
                    tw = clip32(qva_tb_pkg::fx_mul(ax, bx) + qva_tb_pkg::fx_mul(ay, by)
                                + qva_tb_pkg::fx_mul(az, bz), flag);
                    tx = clip32(qva_tb_pkg::fx_mul(aw, bx) - qva_tb_pkg::fx_mul(ay, bz)
                                + qva_tb_pkg::fx_mul(az, by), flag);
                    ty = clip32(qva_tb_pkg::fx_mul(aw, by) + qva_tb_pkg::fx_mul(ax, bz)
                                - qva_tb_pkg::fx_mul(az, bx), flag);
                    tz = clip32(qva_tb_pkg::fx_mul(aw, bz) - qva_tb_pkg::fx_mul(ax, by)
                                + qva_tb_pkg::fx_mul(ay, bx), flag);
                    rx = clip32(qva_tb_pkg::fx_mul(tw, ax) + qva_tb_pkg::fx_mul(tx, aw)
                                + qva_tb_pkg::fx_mul(ty, az) - qva_tb_pkg::fx_mul(tz, ay),
                                flag);
                    ry = clip32(qva_tb_pkg::fx_mul(tw, ay) - qva_tb_pkg::fx_mul(tx, az)
                                + qva_tb_pkg::fx_mul(ty, aw) + qva_tb_pkg::fx_mul(tz, ax),
                                flag);
                    rz = clip32(qva_tb_pkg::fx_mul(tw, az) + qva_tb_pkg::fx_mul(tx, ay)
                                - qva_tb_pkg::fx_mul(ty, ax) + qva_tb_pkg::fx_mul(tz, aw),
                                flag);
                end
                qva_pkg::FN_DOT:
                    rw = clip32(qva_tb_pkg::fx_mul(ax, bx) + qva_tb_pkg::fx_mul(ay, by)
                                + qva_tb_pkg::fx_mul(az, bz), flag);
                qva_pkg::FN_CROSS:
                begin
                    rx = clip32(qva_tb_pkg::fx_mul(ay, bz) - qva_tb_pkg::fx_mul(az, by), flag);
                    ry = clip32(qva_tb_pkg::fx_mul(az, bx) - qva_tb_pkg::fx_mul(ax, bz), flag);
                    rz = clip32(qva_tb_pkg::fx_mul(ax, by) - qva_tb_pkg::fx_mul(ay, bx), flag);
                end
                qva_pkg::FN_SCALE:
                begin
                    rx = clip32(qva_tb_pkg::fx_mul(ax, bw), flag);
                    ry = clip32(qva_tb_pkg::fx_mul(ay, bw), flag);
                    rz = clip32(qva_tb_pkg::fx_mul(az, bw), flag);
                end
                default:
                begin
                end
            endcase
            r.r_w = rw[31:0];
            r.r_x = rx[31:0];
            r.r_y = ry[31:0];
            r.r_z = rz[31:0];
            r.saturated = flag;
            return r;
        end
    endfunction

    function automatic logic [31:0] pick_value();
        begin
            case ($urandom_range(0, 9))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0001_0000;
                3: return 32'hffff_0000;
                4: return 32'h0;
                5, 6: return $urandom();
                default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            endcase
        end
    endfunction

    function automatic qva_pkg::req_t random_word();
        qva_pkg::req_t w;
        begin
            // Codes six and seven show up now and then as noise.
            w.func = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
            w.a_w = pick_value(); w.a_x = pick_value();
            w.a_y = pick_value(); w.a_z = pick_value();
            w.b_w = pick_value(); w.b_x = pick_value();
            w.b_y = pick_value(); w.b_z = pick_value();
            return w;
        end
    endfunction

    function automatic int gap_length();
        begin
            if ($urandom_range(0, 3) != 0)
                return 0;
            if ($urandom_range(0, 9) == 0)
                return $urandom_range(5, 20);
            return $urandom_range(1, 3);
        end
    endfunction

    function automatic qva_pkg::req_t make_word(input logic [2:0] fn, input logic [31:0] v);
        qva_pkg::req_t w;
        begin
            w.func = fn;
            w.a_w = v; w.a_x = v; w.a_y = v; w.a_z = v;
            w.b_w = v; w.b_x = v; w.b_y = v; w.b_z = v;
            return w;
        end
    endfunction

    function automatic qva_pkg::rsp_t make_result(input logic [31:0] w, input logic [31:0] x,
                                                  input logic [31:0] y, input logic [31:0] z,
                                                  input logic s);
        qva_pkg::rsp_t r;
        begin
            r.r_w = w; r.r_x = x; r.r_y = y; r.r_z = z; r.saturated = s;
            return r;
        end
    endfunction

    task automatic add_row(input qva_pkg::req_t w, input bit known, input qva_pkg::rsp_t r);
        stim_row_t row;
        begin
            row.word = w;
            row.known = known;
            row.result = r;
            dir_rows.push_back(row);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input qva_pkg::req_t w);
        int gap;
        begin
            gap = gap_length();
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            req.valid <= 1'b1;
            req.data <= w;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            words_sent++;
            @(negedge clk);
        end
    endtask

    // Result side: random back-pressure, compare each accepted word in order.
    initial
    begin
        int            stall;
        qva_pkg::rsp_t want;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = gap_length();
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            if (rsp.valid)
            begin
                results_seen++;
                if (result_queue.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, got %p", $time, rsp.data);
                    error_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (rsp.data.saturated)
                        sat_seen++;
                    if (rsp.data.r_w !== want.r_w)
                    begin
                        $display("%0t: r_w expected %h got %h", $time, want.r_w, rsp.data.r_w);
                        error_count++;
                    end
                    if (rsp.data.r_x !== want.r_x)
                    begin
                        $display("%0t: r_x expected %h got %h", $time, want.r_x, rsp.data.r_x);
                        error_count++;
                    end
                    if (rsp.data.r_y !== want.r_y)
                    begin
                        $display("%0t: r_y expected %h got %h", $time, want.r_y, rsp.data.r_y);
                        error_count++;
                    end
                    if (rsp.data.r_z !== want.r_z)
                    begin
                        $display("%0t: r_z expected %h got %h", $time, want.r_z, rsp.data.r_z);
                        error_count++;
                    end
                    if (rsp.data.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated expected %b got %b", $time,
                                 want.saturated, rsp.data.saturated);
                        error_count++;
                    end
                end
            end
        end
    end

    // Sender: a directed table first, then random words.
    initial
    begin
        qva_pkg::req_t w;
        int            wait_cycles;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        error_count = 0;
        words_sent = 0;
        results_seen = 0;
        sat_seen = 0;

        add_row(make_word(qva_pkg::FN_CONJ, 32'h0), 1'b1, make_result(0, 0, 0, 0, 1'b0));
        add_row(make_word(qva_pkg::FN_CONJ, 32'h8000_0000), 1'b1,
                make_result(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
        add_row(make_word(qva_pkg::FN_CONJ, 32'h7fff_ffff), 1'b1,
                make_result(32'h7fff_ffff, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 1'b0));
        add_row(make_word(3'd6, 32'h7fff_ffff), 1'b1, make_result(0, 0, 0, 0, 1'b0));
        add_row(make_word(3'd7, 32'h8000_0000), 1'b1, make_result(0, 0, 0, 0, 1'b0));
        add_row(make_word(qva_pkg::FN_DOT, 32'h0001_0000), 1'b1,
                make_result(32'h0003_0000, 0, 0, 0, 1'b0));
        add_row(make_word(qva_pkg::FN_CROSS, 32'h7fff_ffff), 1'b1,
                make_result(0, 0, 0, 0, 1'b0));
        add_row(make_word(qva_pkg::FN_SCALE, 32'h0001_0000), 1'b1,
                make_result(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        add_row(make_word(qva_pkg::FN_DOT, 32'h8000_0000), 1'b1,
                make_result(32'h7fff_ffff, 0, 0, 0, 1'b1));
        add_row(make_word(qva_pkg::FN_SCALE, 32'h8000_0000), 1'b1,
                make_result(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
        foreach (func_list[i])
        begin
            add_row(make_word(func_list[i], 32'hffff_ffff), 1'b0, '0);
            add_row(make_word(func_list[i], 32'h7fff_ffff), 1'b0, '0);
            w = make_word(func_list[i], 32'h0001_0000);
            w.a_x = 32'h0; w.a_y = 32'h0; w.a_z = 32'h0;
            w.b_x = 32'h0002_8000; w.b_y = 32'hfffe_0000; w.b_z = 32'h0000_8000;
            add_row(w, 1'b0, '0);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            result_queue.push_back(dir_rows[i].known ? dir_rows[i].result
                                                     : alu_result(dir_rows[i].word));
            send_word(dir_rows[i].word);
        end
        repeat (RAND_WORDS)
        begin
            w = random_word();
            result_queue.push_back(alu_result(w));
            send_word(w);
        end
        req.valid <= 1'b0;

        wait_cycles = 0;
        while (result_queue.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4 * qva_tb_pkg::LATENCY) @(posedge clk);
        if (result_queue.size() != 0)
        begin
            $display("%0d result words never arrived", result_queue.size());
            error_count++;
        end
        $display("Sent %0d operand words, checked %0d result words (%0d saturated).",
                 words_sent, results_seen, sat_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
